// ===== design/gsh_pkg.sv =====
// Shared types and constants for the Gauss-Seidel heat grid solver.
// No dependencies; imported by gsh_cell_upd, the top level and the testbench.
package gsh_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int VAL_W      = FRAC_BITS + 1;
  localparam int ALPHA_W    = 24;
  localparam int ALPHA_FRAC = 16;
  localparam int GAIN_W     = 25;
  localparam int GAIN_FRAC  = 24;
  localparam int SIZE_W     = 7;
  localparam int SWEEP_W    = 16;
  localparam int COUNT_W    = 17;
  localparam int THR_W      = 40;
  localparam int SUM_W      = VAL_W + 2;
  localparam int T_W        = SUM_W + ALPHA_W - ALPHA_FRAC;
  localparam int U_W        = T_W + 1;
  localparam int SPLIT_W    = (U_W + 1) / 2;
  localparam int PART_W     = SPLIT_W + GAIN_W;
  localparam int TOTAL_W    = PART_W + SPLIT_W;
  localparam int IDX_IN_W   = 6;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [VAL_W-1:0] ONE_VAL = VAL_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ALPHA     = 3'd0,
    REG_GAIN      = 3'd1,
    REG_GRID_SIZE = 3'd2,
    REG_MAX_SWEEP = 3'd3,
    REG_THRESHOLD = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
    logic [VAL_W-1:0] old;
  } upd_req_t;

endpackage

// ===== design/gsh_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module gsh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== design/gsh_cell_upd.sv =====
// Three-stage cell update pipeline: scale neighbour sum by alpha, add old
// value, scale by the reciprocal gain in two partial products, saturate.
// Depends on gsh_pkg.
module gsh_cell_upd (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gsh_pkg::upd_req_t             req,
  input  logic [gsh_pkg::ALPHA_W-1:0]   alpha,
  input  logic [gsh_pkg::GAIN_W-1:0]    gain,
  output logic                          done,
  output logic [gsh_pkg::VAL_W-1:0]     value
);
  import gsh_pkg::*;

  logic [2:0]                      vld_r;
  logic [T_W-1:0]                  t_r;
  logic [VAL_W-1:0]                old_r;
  logic [SUM_W+ALPHA_W-1:0]        prod_a;
  logic [U_W-1:0]                  u;
  logic [2*SPLIT_W-1:0]            u_ext;
  logic [PART_W-1:0]               plo_r, phi_r;
  logic [TOTAL_W-1:0]              total;
  logic [TOTAL_W-GAIN_FRAC-1:0]    scaled;
  logic [VAL_W-1:0]                value_r;

  assign prod_a = SUM_W'(req.sum) * ALPHA_W'(alpha);
  assign u      = U_W'(t_r) + U_W'(old_r);
  assign u_ext  = (2*SPLIT_W)'(u);
  assign total  = (TOTAL_W'(phi_r) << SPLIT_W) + TOTAL_W'(plo_r);
  assign scaled = total[TOTAL_W-1:GAIN_FRAC];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], req.start};
    end
    t_r     <= prod_a[SUM_W+ALPHA_W-1:ALPHA_FRAC];
    old_r   <= req.old;
    plo_r   <= u_ext[SPLIT_W-1:0] * gain;
    phi_r   <= u_ext[2*SPLIT_W-1:SPLIT_W] * gain;
    value_r <= (scaled > (TOTAL_W-GAIN_FRAC)'(ONE_VAL)) ? ONE_VAL : VAL_W'(scaled);
  end

  assign done  = vld_r[2];
  assign value = value_r;

endmodule

// ===== design/gauss_seidel_heat_grid_solver.sv =====
// Gauss-Seidel heat grid solver, top level: control sequencer, grid memory,
// configuration registers and result register. Depends on gsh_pkg, gsh_ram, gsh_cell_upd.
//
// A solve item first writes every one of the GRID_MAX*GRID_MAX grid entries
// (one per cycle), then runs sweeps over rows 0..m-1, columns 1..m-2. Each cell
// takes five reads of the single grid memory port (up, down, left, right,
// center), a pass through the three-stage update pipeline, then the write-back.
// A read item passes through S_RD and S_RESP. One item is worked on at a time;
// the result register lets the next item be taken while a result waits.
module gauss_seidel_heat_grid_solver #(
  parameter int GRID_MAX = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,  // row[5:0], column[11:6]
  input  logic                            in_tuser,  // mode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [47:0]                     out_tdata, // cell_value[24:0], sweeps_done[41:25], converged[42]
  input  logic                            cfg_we,
  input  logic [gsh_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [gsh_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import gsh_pkg::*;

  localparam int IDXW  = $clog2(GRID_MAX);
  localparam int MW    = $clog2(GRID_MAX + 1);
  localparam int AW    = 2 * IDXW;
  localparam int GS_W  = MW + SIZE_W;
  localparam logic [2:0] RD_UP = 3'd0;
  localparam logic [2:0] RD_DN = 3'd1;
  localparam logic [2:0] RD_LF = 3'd2;
  localparam logic [2:0] RD_RT = 3'd3;
  localparam logic [2:0] RD_CT = 3'd4;
  localparam logic [2:0] RD_END = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_INIT, S_FETCH, S_CALC, S_CHECK, S_RESP
  } state_t;

  state_t               state_r;
  logic [ALPHA_W-1:0]   alpha_r;
  logic [GAIN_W-1:0]    gain_r;
  logic [SIZE_W-1:0]    size_r;
  logic [SWEEP_W-1:0]   max_r;
  logic [THR_W-1:0]     thr_r;
  logic [MW-1:0]        m_r, i_r, j_r;
  logic [2:0]           rd_cnt_r;
  logic [SUM_W-1:0]     sum_r;
  logic [VAL_W-1:0]     old_r;
  logic [THR_W-1:0]     diff_r;
  logic [COUNT_W-1:0]   k_r, sweeps_r;
  logic                 conv_r, grid_ok_r, rd_zero_r;
  logic [VAL_W-1:0]     res_val_r;
  logic                 out_vld_r;
  logic [VAL_W-1:0]     out_val_r;
  logic [COUNT_W-1:0]   out_sweeps_r;
  logic                 out_conv_r;

  logic                 in_fire;
  logic [GS_W-1:0]      gs_ext;
  logic [MW-1:0]        m_clamp;
  logic [IDX_IN_W-1:0]  in_row, in_col;
  logic                 in_oob;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [VAL_W-1:0]     ram_wdata, ram_q;
  logic [MW-1:0]        up_row, dn_row, rd_row, rd_col;
  upd_req_t             upd_req;
  logic                 upd_done;
  logic [VAL_W-1:0]     upd_val;
  logic [VAL_W-1:0]     abs_chg;
  logic [COUNT_W-1:0]   k_inc;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_row    = in_tdata[5:0];
  assign in_col    = in_tdata[11:6];
  assign in_oob    = ((GS_W)'(in_row) >= GS_W'(GRID_MAX)) ||
                     ((GS_W)'(in_col) >= GS_W'(GRID_MAX));

  assign gs_ext  = GS_W'(size_r);
  assign m_clamp = (gs_ext < GS_W'(3)) ? MW'(3) :
                   (gs_ext > GS_W'(GRID_MAX)) ? MW'(GRID_MAX) : MW'(gs_ext);

  assign up_row = (i_r == '0) ? MW'(1) : i_r - MW'(1);
  assign dn_row = (i_r == m_r - MW'(1)) ? m_r - MW'(2) : i_r + MW'(1);

  always_comb begin
    rd_row = i_r;
    rd_col = j_r;
    case (rd_cnt_r)
      RD_UP:   rd_row = up_row;
      RD_DN:   rd_row = dn_row;
      RD_LF:   rd_col = j_r - MW'(1);
      RD_RT:   rd_col = j_r + MW'(1);
      RD_CT:   rd_row = i_r;
      default: rd_row = i_r;
    endcase
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {rd_row[IDXW-1:0], rd_col[IDXW-1:0]};
    if (state_r == S_IDLE) begin
      ram_re    = in_fire && in_tuser && !in_oob;
      ram_raddr = {IDXW'(in_row), IDXW'(in_col)};
    end else if (state_r == S_FETCH) begin
      ram_re    = (rd_cnt_r < RD_END);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {i_r[IDXW-1:0], j_r[IDXW-1:0]};
    ram_wdata = upd_val;
    if (state_r == S_INIT) begin
      ram_we    = 1'b1;
      ram_wdata = ((j_r == '0) && (i_r < m_r)) ? ONE_VAL : '0;
    end else if (state_r == S_CALC) begin
      ram_we    = upd_done;
    end
  end

  assign upd_req.start = (state_r == S_FETCH) && (rd_cnt_r == RD_END);
  assign upd_req.sum   = sum_r;
  assign upd_req.old   = ram_q;

  assign abs_chg = (old_r > upd_val) ? old_r - upd_val : upd_val - old_r;
  assign k_inc   = k_r + COUNT_W'(1);

  gsh_ram #(
    .WIDTH (VAL_W),
    .DEPTH (1 << AW)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  gsh_cell_upd u_upd (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (upd_req),
    .alpha (alpha_r),
    .gain  (gain_r),
    .done  (upd_done),
    .value (upd_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      alpha_r   <= ALPHA_W'(65536);
      gain_r    <= GAIN_W'(3355443);
      size_r    <= SIZE_W'(64);
      max_r     <= SWEEP_W'(6400);
      thr_r     <= THR_W'(68719);
      sweeps_r  <= '0;
      conv_r    <= 1'b0;
      grid_ok_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_ALPHA:     alpha_r <= cfg_wdata[ALPHA_W-1:0];
          REG_GAIN:      gain_r  <= cfg_wdata[GAIN_W-1:0];
          REG_GRID_SIZE: size_r  <= cfg_wdata[SIZE_W-1:0];
          REG_MAX_SWEEP: max_r   <= cfg_wdata[SWEEP_W-1:0];
          REG_THRESHOLD: thr_r   <= cfg_wdata[THR_W-1:0];
          default:       ;
        endcase
      end
      if (state_r == S_RESP && (!out_vld_r || out_tready)) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_tuser) begin
              rd_zero_r <= in_oob || !grid_ok_r;
              state_r   <= S_RD;
            end else begin
              m_r       <= m_clamp;
              i_r       <= '0;
              j_r       <= '0;
              grid_ok_r <= 1'b1;
              state_r   <= S_INIT;
            end
          end
        end
        S_RD: begin
          res_val_r <= rd_zero_r ? '0 : ram_q;
          state_r   <= S_RESP;
        end
        S_INIT: begin
          if (j_r == MW'(GRID_MAX - 1)) begin
            if (i_r == MW'(GRID_MAX - 1)) begin
              i_r      <= '0;
              j_r      <= MW'(1);
              k_r      <= '0;
              diff_r   <= '0;
              sum_r    <= '0;
              rd_cnt_r <= RD_UP;
              state_r  <= S_FETCH;
            end else begin
              j_r <= '0;
              i_r <= i_r + MW'(1);
            end
          end else begin
            j_r <= j_r + MW'(1);
          end
        end
        S_FETCH: begin
          rd_cnt_r <= rd_cnt_r + 3'd1;
          if (rd_cnt_r != RD_UP && rd_cnt_r != RD_END) begin
            sum_r <= sum_r + SUM_W'(ram_q);
          end
          if (rd_cnt_r == RD_END) begin
            old_r   <= ram_q;
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (upd_done) begin
            if (i_r != '0 && i_r != m_r - MW'(1)) begin
              diff_r <= diff_r + THR_W'(abs_chg);
            end
            sum_r    <= '0;
            rd_cnt_r <= RD_UP;
            if (j_r == m_r - MW'(2)) begin
              j_r <= MW'(1);
              if (i_r == m_r - MW'(1)) begin
                state_r <= S_CHECK;
              end else begin
                i_r     <= i_r + MW'(1);
                state_r <= S_FETCH;
              end
            end else begin
              j_r     <= j_r + MW'(1);
              state_r <= S_FETCH;
            end
          end
        end
        S_CHECK: begin
          k_r <= k_inc;
          if (k_inc <= COUNT_W'(max_r) && diff_r > thr_r) begin
            i_r      <= '0;
            j_r      <= MW'(1);
            diff_r   <= '0;
            sum_r    <= '0;
            rd_cnt_r <= RD_UP;
            state_r  <= S_FETCH;
          end else begin
            sweeps_r  <= k_inc;
            conv_r    <= (diff_r <= thr_r);
            res_val_r <= '0;
            state_r   <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_vld_r || out_tready) begin
            out_val_r    <= res_val_r;
            out_sweeps_r <= sweeps_r;
            out_conv_r   <= conv_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_conv_r, out_sweeps_r, out_val_r};

endmodule

// ===== tb/gauss_seidel_heat_grid_solver_tb.sv =====
// Testbench for gauss_seidel_heat_grid_solver: solve and cell read transfers under
// several register settings and idle patterns, checked against an in-bench predictor.
// Depends on gsh_pkg and the solver RTL only.
module gauss_seidel_heat_grid_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsh_pkg::*;

  localparam int GMAX = 64;
  localparam logic MODE_SOLVE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [5:0] row;
    logic [5:0] column;
  } cell_req_t;

  typedef struct packed {
    logic        converged;
    logic [16:0] sweeps_done;
    logic [24:0] cell_value;
  } cell_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  gauss_seidel_heat_grid_solver DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] grid_q[GMAX*GMAX];
  logic [16:0] last_sweeps;
  logic        last_conv;
  logic [63:0] m_alpha, m_gain, m_size, m_maxsw, m_thr;

  cell_req_t pending_q[$];
  cell_rsp_t cell_rsp_q[$];
  cell_req_t cur_req;
  int send_idle = 0, recv_idle = 0;
  int errors = 0, solves = 0, reads = 0;

  function automatic logic [63:0] mul_floor(logic [63:0] a, logic [63:0] b, int sh,
                                            logic [63:0] cap);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    return (p > {64'd0, cap}) ? cap : p[63:0];
  endfunction

  function automatic void heat_solve();
    int m;
    logic [63:0] k, diff, old, s, t, v;
    m = int'(m_size);
    k = 0;
    if (m < 3) m = 3;
    if (m > GMAX) m = GMAX;
    foreach (grid_q[n]) grid_q[n] = 0;
    for (int i = 0; i < m; i++) grid_q[i*GMAX] = 64'd1 << FRAC_BITS;
    do begin
      diff = 0;
      for (int i = 0; i < m; i++) begin
        for (int j = 1; j + 1 < m; j++) begin
          old = grid_q[i*GMAX+j];
          if (i == 0) s = 2 * grid_q[GMAX+j];
          else if (i == m - 1) s = 2 * grid_q[(m-2)*GMAX+j];
          else s = grid_q[(i-1)*GMAX+j] + grid_q[(i+1)*GMAX+j];
          s += grid_q[i*GMAX+j-1] + grid_q[i*GMAX+j+1];
          t = mul_floor(s, m_alpha, ALPHA_FRAC, 64'd1 << 62);
          v = mul_floor(t + old, m_gain, GAIN_FRAC, 64'd1 << FRAC_BITS);
          grid_q[i*GMAX+j] = v;
          if (i != 0 && i != m - 1) diff += (old > v) ? old - v : v - old;
        end
      end
      k++;
    end while (k <= m_maxsw && diff > m_thr);
    last_sweeps = k[16:0];
    last_conv = (diff <= m_thr);
  endfunction

  function automatic cell_rsp_t predict_cell(cell_req_t r);
    cell_rsp_t e;
    e.cell_value = '0;
    if (r.mode == MODE_SOLVE) begin
      heat_solve();
      solves++;
    end else begin
      e.cell_value = grid_q[r.row*GMAX + r.column][24:0];
      reads++;
    end
    e.sweeps_done = last_sweeps;
    e.converged = last_conv;
    return e;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) cell_rsp_q.push_back(predict_cell(cur_req));
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur_req = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {4'd0, cur_req.column, cur_req.row};
          in_tuser <= cur_req.mode;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cell_rsp_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[42:0];
        if (cell_rsp_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = cell_rsp_q.pop_front();
          if (got.cell_value !== want.cell_value) begin
            $display("%0t: cell_value expected %h actual %h", $time,
                     want.cell_value, got.cell_value);
            errors++;
          end
          if (got.sweeps_done !== want.sweeps_done) begin
            $display("%0t: sweeps_done expected %0d actual %0d", $time,
                     want.sweeps_done, got.sweeps_done);
            errors++;
          end
          if (got.converged !== want.converged) begin
            $display("%0t: converged expected %0d actual %0d", $time,
                     want.converged, got.converged);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || in_tvalid || cell_rsp_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_ALPHA:     m_alpha = val & 64'hFF_FFFF;
      REG_GAIN:      m_gain = val & 64'h1FF_FFFF;
      REG_GRID_SIZE: m_size = val & 64'h7F;
      REG_MAX_SWEEP: m_maxsw = val & 64'hFFFF;
      REG_THRESHOLD: m_thr = val & 64'hFF_FFFF_FFFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic setup(logic [63:0] a, logic [63:0] g, logic [63:0] sz,
                       logic [63:0] ms, logic [63:0] th);
    drain();
    write_reg(REG_ALPHA, a);
    write_reg(REG_GAIN, g);
    write_reg(REG_GRID_SIZE, sz);
    write_reg(REG_MAX_SWEEP, ms);
    write_reg(REG_THRESHOLD, th);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push(logic mode, int r, int c);
    cell_req_t q;
    q.mode = mode;
    q.row = r[5:0];
    q.column = c[5:0];
    pending_q.push_back(q);
  endtask

  initial begin
    logic [63:0] a;
    m_alpha = 65536; m_gain = 3355443; m_size = 64; m_maxsw = 6400; m_thr = 68719;
    foreach (grid_q[n]) grid_q[n] = 0;
    last_sweeps = 0;
    last_conv = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push(MODE_READ, 0, 0);
    push(MODE_READ, 63, 63);
    setup(0, 16777216, 0, 1, 0);
    push(MODE_SOLVE, 63, 63);
    push(MODE_READ, 0, 0);
    push(MODE_READ, 1, 1);
    push(MODE_READ, 63, 63);
    setup(16777215, 0, 3, 65535, 64'hFF_FFFF_FFFF);
    push(MODE_SOLVE, 0, 0);
    push(MODE_READ, 1, 1);
    push(MODE_READ, 2, 0);
    setup(65536, 3355443, 5, 3, 0);
    push(MODE_SOLVE, 5, 7);
    push(MODE_READ, 0, 1);
    push(MODE_READ, 2, 2);
    push(MODE_READ, 4, 3);
    setup(65536, 3355443, 127, 1, 0);
    push(MODE_SOLVE, 0, 0);
    push(MODE_READ, 10, 10);
    push(MODE_READ, 63, 62);
    push(MODE_READ, 0, 62);

    for (int ph = 0; ph < 4; ph++) begin
      a = $urandom_range(0, 1 << 18);
      setup(a, (64'd1 << 40) / (64'd65536 + 4 * a), $urandom_range(3, 8),
            $urandom_range(1, 40),
            ($urandom_range(1) != 0) ? 64'($urandom_range(0, 1 << 22))
                                     : {$urandom, $urandom});
      send_idle = (ph == 1) ? 78 : (ph == 3) ? 32 : 0;
      recv_idle = (ph == 2) ? 78 : (ph == 3) ? 32 : 0;
      for (int n = 0; n < 25; n++)
        push(($urandom_range(3) == 0) ? MODE_SOLVE : MODE_READ,
             ($urandom_range(1) != 0) ? $urandom_range(0, 8) : $urandom_range(0, 63),
             ($urandom_range(1) != 0) ? $urandom_range(0, 8) : $urandom_range(0, 63));
    end
    drain();
    repeat (50) @(posedge clk);
    $display("Covered %0d solves and %0d cell reads over 9 register settings,", solves, reads);
    $display("with no idling, sender gaps, receiver stalls and both together.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
design/gsh_pkg.sv
design/gsh_ram.sv
design/gsh_cell_upd.sv
design/gauss_seidel_heat_grid_solver.sv
tb/gauss_seidel_heat_grid_solver_tb.sv
